// ===== design/tfi_pkg.sv =====
`timescale 1ns / 1ps
package tfi_pkg;

   localparam int ADDR_W   = 12;
   localparam int DEPTH    = 4096;
   localparam int CORNERS  = 8;
   localparam int COMPS    = 3;
   localparam int WORD_W   = 32 * COMPS;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z  = 3'd5;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [11:0]        load_index;
      logic signed [31:0] load_comp_x;
      logic signed [31:0] load_comp_y;
      logic signed [31:0] load_comp_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] field_out_x;
      logic signed [31:0] field_out_y;
      logic signed [31:0] field_out_z;
      logic               inside_res;
   } rsp_type;

   // a + (b - a) * f / 65536, floored; result stays between a and b
   function automatic logic signed [31:0] lerp16(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic [15:0] f);
      logic signed [32:0] diff;
      logic signed [49:0] prod;
      logic signed [49:0] acc;
      diff = 33'(b) - 33'(a);
      prod = 50'(diff) * 50'($signed({1'b0, f}));
      acc  = {{2{a[31]}}, a, 16'h0000} + prod;
      return acc[47:16];
   endfunction

endpackage

// ===== design/tfi_ram.sv =====
`timescale 1ns / 1ps
module tfi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule

// ===== design/tfi_axis.sv =====
`timescale 1ns / 1ps
module tfi_axis #(
   parameter int N_POINTS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] pos,
   input  logic signed [31:0] origin,
   input  logic signed [31:0] scale,
   output logic [11:0]        cell_ff,
   output logic [15:0]        frac_ff,
   output logic               inside_ff
);
   import tfi_pkg::*;

   logic signed [32:0] d_ff, d_in;
   logic signed [64:0] g_ff, g_in;
   logic               inside_in;

   assign d_in = 33'(pos) - 33'(origin);
   assign g_in = 65'(d_ff) * 65'(scale);
   // negative grid coordinate is outside, even within one cell of zero
   assign inside_in = !g_ff[64] && (g_ff[63:32] < 32'(N_POINTS - 1));

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff      <= d_in;
         g_ff      <= g_in;
         cell_ff   <= g_ff[32 +: ADDR_W];
         frac_ff   <= g_ff[31:16];
         inside_ff <= inside_in;
      end
   end
endmodule

// ===== design/trilinear_field_interpolator_core.sv =====
`timescale 1ns / 1ps
// Trilinear field interpolator.
// req channel (valid/ready) carries one transaction per cycle unless stalled:
// a load writes one entry of the three component grids at load_index, a query
// maps pos_x/y/z through origin and scale to a grid cell and blends its eight corners.
// rsp channel (valid/ready) returns one result per query; loads give none.
// csr port writes origin/scale registers; write only when the pipeline is empty.
// Throughput: one transaction per cycle while rsp_ready does not hold the
// pipe, set by the seven-stage pipeline and eight replicated grid memories
// (one read port per cell corner).
// Loads commit in stage 3, in order with queries, so a query sees every load
// accepted before it.
// Reset clears the valid bits and sets origin 0, scale 1.0; grid contents are
// undefined until loaded.
// When rsp_ready is low with a result pending, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated.
module trilinear_field_interpolator_core #(
   parameter int GRID_X = 16,
   parameter int GRID_Y = 16,
   parameter int GRID_Z = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tfi_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tfi_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [tfi_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [31:0]                    csr_wdata
);
   import tfi_pkg::*;

   localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(GRID_X);
   localparam logic [ADDR_W-1:0] SIZE_Y   = ADDR_W'(GRID_Y);

   logic en;

   logic signed [31:0] origin_ff [COMPS];
   logic signed [31:0] scale_ff  [COMPS];

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff, s7_vld_ff;
   logic s4_vld_in;
   req_type s1_ff, s2_ff, s3_ff;

   logic [11:0] cx, cy, cz;
   logic [15:0] fx, fy, fz;
   logic        inx, iny, inz;

   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] corner_addr [CORNERS];
   logic [WORD_W-1:0] corner_data [CORNERS];
   logic              ram_we;
   logic [WORD_W-1:0] ram_wdata;

   logic [15:0] s4_fx_ff, s4_fy_ff, s4_fz_ff, s5_fy_ff, s5_fz_ff, s6_fz_ff;
   logic        s4_in_ff, s5_in_ff, s6_in_ff;

   logic signed [31:0] lx_ff [COMPS][4];
   logic signed [31:0] ly_ff [COMPS][2];
   rsp_type            rsp_ff, rsp_in;

   assign en        = !s7_vld_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = s7_vld_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COMPS; i++) begin
            origin_ff[i] <= 32'sd0;
            scale_ff[i]  <= 32'sd65536;
         end
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            CSR_SCALE_X:  scale_ff[0]  <= csr_wdata;
            CSR_SCALE_Y:  scale_ff[1]  <= csr_wdata;
            CSR_SCALE_Z:  scale_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits; loads leave the pipe after committing in stage 3
   assign s4_vld_in = s3_vld_ff && (s3_ff.action == ACT_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s4_vld_in;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= req_data;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   // stages 1..3: coordinate mapping per axis
   tfi_axis #(.N_POINTS(GRID_X)) u_axis_x (
      .clock(clock), .en(en), .pos(req_data.pos_x), .origin(origin_ff[0]),
      .scale(scale_ff[0]), .cell_ff(cx), .frac_ff(fx), .inside_ff(inx));
   tfi_axis #(.N_POINTS(GRID_Y)) u_axis_y (
      .clock(clock), .en(en), .pos(req_data.pos_y), .origin(origin_ff[1]),
      .scale(scale_ff[1]), .cell_ff(cy), .frac_ff(fy), .inside_ff(iny));
   tfi_axis #(.N_POINTS(GRID_Z)) u_axis_z (
      .clock(clock), .en(en), .pos(req_data.pos_z), .origin(origin_ff[2]),
      .scale(scale_ff[2]), .cell_ff(cz), .frac_ff(fz), .inside_ff(inz));

   // corner addresses, all modulo the store depth
   assign base = cx + STRIDE_Y * (cy + SIZE_Y * cz);

   assign ram_we    = en && s3_vld_ff && (s3_ff.action == ACT_LOAD);
   assign ram_wdata = {s3_ff.load_comp_x, s3_ff.load_comp_y, s3_ff.load_comp_z};

   for (genvar c = 0; c < CORNERS; c++) begin : g_corner
      localparam logic [ADDR_W-1:0] OFFS =
         ADDR_W'((c % 2) + GRID_X * ((c / 2) % 2) + GRID_X * GRID_Y * (c / 4));

      assign corner_addr[c] = base + OFFS;

      tfi_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
         .clock(clock),
         .we(ram_we),
         .waddr(s3_ff.load_index),
         .wdata(ram_wdata),
         .re(en),
         .raddr(corner_addr[c]),
         .rdata(corner_data[c]));
   end

   // stage 4 side data travels with the memory read
   always_ff @(posedge clock) begin
      if (en) begin
         s4_fx_ff <= fx;
         s4_fy_ff <= fy;
         s4_fz_ff <= fz;
         s4_in_ff <= inx && iny && inz;
         s5_fy_ff <= s4_fy_ff;
         s5_fz_ff <= s4_fz_ff;
         s5_in_ff <= s4_in_ff;
         s6_fz_ff <= s5_fz_ff;
         s6_in_ff <= s5_in_ff;
      end
   end

   // stages 5..7: blend along x, then y, then z
   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < COMPS; m++) begin
            for (int k = 0; k < 4; k++) begin
               lx_ff[m][k] <= lerp16(corner_data[2*k][32*(2-m) +: 32],
                                     corner_data[2*k+1][32*(2-m) +: 32], s4_fx_ff);
            end
            for (int k = 0; k < 2; k++) begin
               ly_ff[m][k] <= lerp16(lx_ff[m][2*k], lx_ff[m][2*k+1], s5_fy_ff);
            end
         end
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in             = '0;
      if (s6_in_ff) begin
         rsp_in.field_out_x = lerp16(ly_ff[0][0], ly_ff[0][1], s6_fz_ff);
         rsp_in.field_out_y = lerp16(ly_ff[1][0], ly_ff[1][1], s6_fz_ff);
         rsp_in.field_out_z = lerp16(ly_ff[2][0], ly_ff[2][1], s6_fz_ff);
         rsp_in.inside_res  = 1'b1;
      end
   end
endmodule
